// ----- hdl/opts_pkg.sv -----
// package for the one-shot / periodic timer slot pool
// slot count, field widths, operation and status codes, sequencer state type
// no dependencies
package opts_pkg;

   localparam int Slots     = 16;
   localparam int IdxBits   = 4;   // slot handle width, fixed by the slot field
   localparam int CountBits = 5;   // holds 0 .. Slots
   localparam int TimeBits  = 64;

   typedef enum logic [1:0] {
      OP_TICK         = 2'd0,
      OP_ADD_ONESHOT  = 2'd1,
      OP_ADD_PERIODIC = 2'd2,
      OP_REMOVE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_NOT_ENABLED = 2'd2,
      ST_RESERVED    = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      SQ_IDLE = 7'b0000001,
      SQ_OP   = 7'b0000010,
      SQ_READ = 7'b0000100,
      SQ_SUM  = 7'b0001000,
      SQ_DUE  = 7'b0010000,
      SQ_NEXT = 7'b0100000,
      SQ_DONE = 7'b1000000
   } seq_type;

endpackage

// ----- hdl/oneshot_periodic_timer_slots.sv -----
// top level of the timer slot pool: free stack, ordered active list, slot timing
// and a sweep sequencer around one shared 65-bit adder and one 64-bit comparator
// depends on opts_pkg
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  req     | in  | req_tvalid / req_tready | tuser operation, tdata now/interval/slot
//  rsp     | out | rsp_tvalid / rsp_tready | tuser fired, tdata slot/periodic/status,
//          |     |                         | tlast on final result of an input
//
// add and remove are accepted, then update once the output register is free; a tick
// reads each active entry, frees a disabled one, else sums its due time and checks it,
// advancing a fired periodic in a further state, the shared adder and comparator
// setting the per-entry cost; ready only while idle
// synchronous active-high reset empties the active list and refills the free stack
// a stalled output stalls the sweep at its next firing, never drops a result
module oneshot_periodic_timer_slots
   import opts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,    // [1:0] operation
   input  logic [135:0] req_tdata,    // [63:0] now_us, [127:64] interval_us,
                                      // [131:128] slot_sel, [135:132] zero
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,    // [0] fired
   output logic [7:0]   rsp_tdata,    // [3:0] slot_out, [4] was_periodic,
                                      // [6:5] status, [7] zero
   output logic         rsp_tlast
);

   // sequencer and latched request
   seq_type                 state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [TimeBits-1:0]     now_ff, now_in;
   logic [TimeBits-1:0]     ivl_ff, ivl_in;
   logic [IdxBits-1:0]      sel_ff, sel_in;

   // slot storage
   logic [TimeBits-1:0]     start_ff    [Slots];
   logic [TimeBits-1:0]     interval_ff [Slots];
   logic [Slots-1:0]        periodic_ff;
   logic [Slots-1:0]        enabled_ff;
   logic [IdxBits-1:0]      active_ff   [Slots];
   logic [IdxBits-1:0]      free_ff     [Slots];
   logic [CountBits-1:0]    active_count_ff, active_count_in;
   logic [CountBits-1:0]    free_count_ff, free_count_in;

   // sweep registers
   logic [CountBits-1:0]    rd_ff, rd_in;
   logic [CountBits-1:0]    wr_ff, wr_in;
   logic [IdxBits-1:0]      slot_ff, slot_in;
   logic [TimeBits:0]       sum_ff, sum_in;
   logic                    held_valid_ff, held_valid_in;
   logic [IdxBits-1:0]      held_slot_ff, held_slot_in;
   logic                    held_per_ff, held_per_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fired_ff, rsp_fired_in;
   logic [IdxBits-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                    rsp_per_ff, rsp_per_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   // storage write ports
   logic                    act_we;
   logic [IdxBits-1:0]      act_wa, act_wd;
   logic                    free_we;
   logic [IdxBits-1:0]      free_wa, free_wd;
   logic                    start_we;
   logic [IdxBits-1:0]      tim_wa;
   logic [TimeBits-1:0]     start_wd;
   logic                    add_we;
   logic                    en_we, en_wd;

   // shared arithmetic
   logic [TimeBits-1:0]     add_a, cmp_b;
   logic [TimeBits:0]       add_sum;
   logic                    now_ge, now_eq;
   logic                    due, lag;

   logic                    out_free;
   logic                    fire_ok;
   logic                    req_xfer;
   logic [IdxBits-1:0]      rd_slot;
   logic [IdxBits-1:0]      pop_slot;
   logic                    pool_full;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign fire_ok   = !held_valid_ff || out_free;
   assign req_tready = (state_ff == SQ_IDLE);
   assign req_xfer  = req_tvalid && req_tready;
   assign rd_slot   = active_ff[rd_ff[IdxBits-1:0]];
   assign pop_slot  = free_ff[IdxBits'(free_count_ff - CountBits'(1))];
   assign pool_full = (free_count_ff == '0);

   // one adder: start + interval on the sum step, sum + interval on the catch-up step
   assign add_a   = (state_ff == SQ_SUM) ? start_ff[slot_ff] : sum_ff[TimeBits-1:0];
   assign add_sum = {1'b0, add_a} + {1'b0, interval_ff[slot_ff]};

   // one comparator: against the due time, or against the next period boundary
   assign cmp_b  = (state_ff == SQ_DUE) ? sum_ff[TimeBits-1:0] : add_sum[TimeBits-1:0];
   assign now_ge = (now_ff >= cmp_b);
   assign now_eq = (now_ff == cmp_b);
   assign due    = !sum_ff[TimeBits] && now_ge;
   assign lag    = !add_sum[TimeBits] && now_ge && !now_eq;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      now_in          = now_ff;
      ivl_in          = ivl_ff;
      sel_in          = sel_ff;
      active_count_in = active_count_ff;
      free_count_in   = free_count_ff;
      rd_in           = rd_ff;
      wr_in           = wr_ff;
      slot_in         = slot_ff;
      sum_in          = sum_ff;
      held_valid_in   = held_valid_ff;
      held_slot_in    = held_slot_ff;
      held_per_in     = held_per_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_fired_in    = rsp_fired_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_per_in      = rsp_per_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;

      act_we   = 1'b0;
      act_wa   = wr_ff[IdxBits-1:0];
      act_wd   = slot_ff;
      free_we  = 1'b0;
      free_wa  = free_count_ff[IdxBits-1:0];
      free_wd  = slot_ff;
      start_we = 1'b0;
      tim_wa   = slot_ff;
      start_wd = now_ff;
      add_we   = 1'b0;
      en_we    = 1'b0;
      en_wd    = 1'b0;

      unique case (state_ff)
         SQ_IDLE: begin
            if (req_xfer) begin
               op_in  = op_type'(req_tuser);
               now_in = req_tdata[63:0];
               ivl_in = req_tdata[127:64];
               sel_in = req_tdata[131:128];
               if (op_type'(req_tuser) == OP_TICK) begin
                  rd_in         = '0;
                  wr_in         = '0;
                  held_valid_in = 1'b0;
                  state_in      = SQ_READ;
               end else begin
                  state_in = SQ_OP;
               end
            end
         end

         SQ_OP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = 1'b0;
               rsp_per_in   = 1'b0;
               rsp_last_in  = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  // only the enabled bit drops; the next tick frees the slot
                  rsp_slot_in = sel_ff;
                  if (enabled_ff[sel_ff]) begin
                     en_we         = 1'b1;
                     en_wd         = 1'b0;
                     tim_wa        = sel_ff;
                     rsp_status_in = ST_OK;
                  end else begin
                     rsp_status_in = ST_NOT_ENABLED;
                  end
               end else if (pool_full) begin
                  rsp_slot_in   = '0;
                  rsp_status_in = ST_FULL;
               end else begin
                  // pop from the free stack, append to the active list
                  free_count_in   = free_count_ff - CountBits'(1);
                  act_we          = 1'b1;
                  act_wa          = active_count_ff[IdxBits-1:0];
                  act_wd          = pop_slot;
                  active_count_in = active_count_ff + CountBits'(1);
                  tim_wa          = pop_slot;
                  start_we        = 1'b1;
                  start_wd        = now_ff;
                  add_we          = 1'b1;
                  en_we           = 1'b1;
                  en_wd           = 1'b1;
                  rsp_slot_in     = pop_slot;
                  rsp_status_in   = ST_OK;
               end
               state_in = SQ_IDLE;
            end
         end

         SQ_READ: begin
            if (rd_ff == active_count_ff) begin
               state_in = SQ_DONE;
            end else begin
               slot_in = rd_slot;
               rd_in   = rd_ff + CountBits'(1);
               if (!enabled_ff[rd_slot]) begin
                  // removed slot goes back to the free stack
                  free_we       = 1'b1;
                  free_wd       = rd_slot;
                  free_count_in = free_count_ff + CountBits'(1);
               end else begin
                  state_in = SQ_SUM;
               end
            end
         end

         SQ_SUM: begin
            sum_in   = add_sum;
            state_in = SQ_DUE;
         end

         SQ_DUE: begin
            if (!due) begin
               act_we   = 1'b1;
               wr_in    = wr_ff + CountBits'(1);
               state_in = SQ_READ;
            end else if (periodic_ff[slot_ff]) begin
               state_in = SQ_NEXT;
            end else if (fire_ok) begin
               // one-shot fires: disable and free
               start_we      = 1'b1;
               start_wd      = now_ff;
               en_we         = 1'b1;
               en_wd         = 1'b0;
               free_we       = 1'b1;
               free_count_in = free_count_ff + CountBits'(1);
               if (held_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_fired_in  = 1'b1;
                  rsp_slot_in   = held_slot_ff;
                  rsp_per_in    = held_per_ff;
                  rsp_status_in = ST_OK;
                  rsp_last_in   = 1'b0;
               end
               held_valid_in = 1'b1;
               held_slot_in  = slot_ff;
               held_per_in   = 1'b0;
               state_in      = SQ_READ;
            end
         end

         SQ_NEXT: begin
            if (fire_ok) begin
               // periodic fires: advance one period, or jump to now when behind
               start_we = 1'b1;
               start_wd = lag ? now_ff : sum_ff[TimeBits-1:0];
               act_we   = 1'b1;
               wr_in    = wr_ff + CountBits'(1);
               if (held_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_fired_in  = 1'b1;
                  rsp_slot_in   = held_slot_ff;
                  rsp_per_in    = held_per_ff;
                  rsp_status_in = ST_OK;
                  rsp_last_in   = 1'b0;
               end
               held_valid_in = 1'b1;
               held_slot_in  = slot_ff;
               held_per_in   = 1'b1;
               state_in      = SQ_READ;
            end
         end

         SQ_DONE: begin
            active_count_in = wr_ff;
            if (!held_valid_ff) begin
               state_in = SQ_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = 1'b1;
               rsp_slot_in   = held_slot_ff;
               rsp_per_in    = held_per_ff;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = SQ_IDLE;
            end
         end

         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SQ_IDLE;
         active_count_ff <= '0;
         free_count_ff   <= CountBits'(Slots);
         held_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         periodic_ff     <= '0;
         enabled_ff      <= '0;
         for (int i = 0; i < Slots; i++) begin
            free_ff[i] <= IdxBits'(i);
         end
      end else begin
         state_ff        <= state_in;
         active_count_ff <= active_count_in;
         free_count_ff   <= free_count_in;
         held_valid_ff   <= held_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (add_we) begin
            periodic_ff[tim_wa] <= (op_ff == OP_ADD_PERIODIC);
         end
         if (en_we) begin
            enabled_ff[tim_wa] <= en_wd;
         end
         if (free_we) begin
            free_ff[free_wa] <= free_wd;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      ivl_ff        <= ivl_in;
      sel_ff        <= sel_in;
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      slot_ff       <= slot_in;
      sum_ff        <= sum_in;
      held_slot_ff  <= held_slot_in;
      held_per_ff   <= held_per_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_per_ff    <= rsp_per_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (act_we) begin
         active_ff[act_wa] <= act_wd;
      end
      if (start_we) begin
         start_ff[tim_wa] <= start_wd;
      end
      if (add_we) begin
         interval_ff[tim_wa] <= ivl_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_per_ff, rsp_slot_ff};
   assign rsp_tlast  = rsp_last_ff;

   // every slot is either free or on the active list
   a_slot_conservation: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_IDLE) |-> (free_count_ff + active_count_ff == CountBits'(Slots)))
      else $error("free and active counts do not add up to the slot count");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CountBits'(Slots))
      else $error("free stack overflow");

   // compaction never overtakes the read pointer
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_SUM || state_ff == SQ_DUE || state_ff == SQ_NEXT) |-> (wr_ff < rd_ff))
      else $error("active list write pointer passed read pointer");

   // only enabled slots reach the due check
   a_due_enabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQ_DUE) |-> enabled_ff[slot_ff])
      else $error("disabled slot evaluated for expiry");

   // a firing report always carries an ok status
   a_fire_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fired_ff) |-> (rsp_status_ff == ST_OK))
      else $error("firing reported with non-ok status");

endmodule
